// ===== rtl/sfsm_pkg.sv =====
package sfsm_pkg;

    // Number of fault categories that get a counter of their own
    localparam int FAULT_TYPES_DEF = 8;

    // Total fault count at which degraded gives up and goes safe
    localparam logic [31:0] FAULT_LIMIT = 32'd4;

    // Reset values of the configuration registers
    localparam logic [15:0] RECOVERY_OK_RST = 16'd10;
    localparam logic [31:0] TIMEOUT_RST     = 32'd30000;

    // Configuration register indexes
    localparam logic [7:0] CFG_RECOVERY_OK = 8'd0;
    localparam logic [7:0] CFG_TIMEOUT     = 8'd1;

    // Event kinds
    localparam logic [1:0] FUNC_FAULT = 2'd0;
    localparam logic [1:0] FUNC_OK    = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;
    localparam logic [1:0] FUNC_TEST  = 2'd3;

    // Reported state codes
    localparam logic [1:0] CODE_NORMAL     = 2'd0;
    localparam logic [1:0] CODE_DEGRADED   = 2'd1;
    localparam logic [1:0] CODE_SAFE       = 2'd2;
    localparam logic [1:0] CODE_FAILSILENT = 2'd3;

    typedef enum logic [3:0] {
        ST_NORMAL     = 4'b0001,
        ST_DEGRADED   = 4'b0010,
        ST_SAFE       = 4'b0100,
        ST_FAILSILENT = 4'b1000
    } t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  fault_type;
        logic [31:0] tick_value;
        logic        test_pass;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  safety_state;
        logic        actuator_allowed;
        logic        safe_action;
        logic [31:0] total_fault_count;
        logic [15:0] type_fault_count;
        logic        self_test_ok;
    } t_out_item;

    // Top level to fault counters
    typedef struct packed {
        logic       count_en;
        logic [3:0] fault_type;
    } t_cnt_ctrl;

    // Fault counters to top level: counts after the current event
    typedef struct packed {
        logic [31:0] total_next;
        logic [15:0] type_next;
    } t_cnt_status;

    function automatic logic [1:0] state_code(input t_state s);
        logic [1:0] code;
        unique case (s)
            ST_NORMAL:     code = CODE_NORMAL;
            ST_DEGRADED:   code = CODE_DEGRADED;
            ST_SAFE:       code = CODE_SAFE;
            ST_FAILSILENT: code = CODE_FAILSILENT;
            default:       code = CODE_SAFE;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/sfsm_fault_cnt.sv =====
module sfsm_fault_cnt #(
    parameter int FAULT_TYPES = sfsm_pkg::FAULT_TYPES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sfsm_pkg::t_cnt_ctrl   i_ctrl,
    output sfsm_pkg::t_cnt_status o_status
);

    logic [31:0] r_total;
    logic [31:0] n_total;
    logic [15:0] r_type [FAULT_TYPES];
    logic [15:0] n_type [FAULT_TYPES];
    logic [15:0] type_next;

    always_comb begin
        n_total = r_total;
        if (i_ctrl.count_en && (r_total != '1)) begin
            n_total = r_total + 32'd1;
        end
    end

    // Per-type counters saturate; categories outside the range read as zero
    always_comb begin
        type_next = '0;
        for (int i = 0; i < FAULT_TYPES; i++) begin
            n_type[i] = r_type[i];
            if (i_ctrl.count_en && (i_ctrl.fault_type == 4'(i)) && (r_type[i] != '1)) begin
                n_type[i] = r_type[i] + 16'd1;
            end
            if (i_ctrl.fault_type == 4'(i)) begin
                type_next = n_type[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            for (int i = 0; i < FAULT_TYPES; i++) begin
                r_type[i] <= '0;
            end
        end else begin
            r_total <= n_total;
            for (int i = 0; i < FAULT_TYPES; i++) begin
                r_type[i] <= n_type[i];
            end
        end
    end

    assign o_status.total_next = n_total;
    assign o_status.type_next  = type_next;

    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_total >= $past(r_total)))
        else $error("total fault count decreased");

    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(i_ctrl.count_en) |-> $stable(r_total))
        else $error("total fault count moved without a counted fault");

endmodule

// ===== rtl/safety_fault_state_machine_top.sv =====
// A result passes from the input register through the result register, where it is held
// until its transfer out completes; a stall on the result side holds both registers.
// Throughput: one event per cycle while the result side does not stall; the state update
// for an event is combinational between the input register and the result register.
// Reset (i_rst_n low, synchronous): state normal, all fault counters, ok run, entry
// tick and self-test flag zero; recovery count 10, timeout 30000; ready right after.
module safety_fault_state_machine_top #(
    parameter int FAULT_TYPES = sfsm_pkg::FAULT_TYPES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // event channel
    input  logic                i_in_valid,
    input  sfsm_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    // result channel
    output logic                o_out_valid,
    output sfsm_pkg::t_out_item o_out_data,
    input  logic                i_out_stall,
    // configuration write channel
    input  logic                i_cfg_valid,
    input  logic [7:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output logic                o_cfg_ready
);

    // Handshake control
    logic                r_in_valid;
    sfsm_pkg::t_in_item  r_in;
    logic                r_out_valid;
    sfsm_pkg::t_out_item r_out;
    logic                advance;
    logic                in_take;
    logic                process;

    // Configuration registers
    logic [15:0] r_recovery_ok;
    logic [31:0] r_timeout;

    // Supervisor state
    sfsm_pkg::t_state r_state;
    sfsm_pkg::t_state n_state;
    logic [15:0]      r_ok_run;
    logic [15:0]      n_ok_run;
    logic [15:0]      ok_inc;
    logic [31:0]      r_start;
    logic [31:0]      n_start;
    logic             r_flag;
    logic             n_flag;
    logic             pulse;
    logic [31:0]      elapsed;

    sfsm_pkg::t_cnt_ctrl   cnt_ctrl;
    sfsm_pkg::t_cnt_status cnt_status;

    // The result register moves when it is empty or its transfer completes now.
    // The input register moves into processing whenever the result side moves.
    assign advance     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !advance;
    assign in_take     = i_in_valid && !o_in_stall;
    assign process     = r_in_valid && advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload holds until the next transfer, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // Configuration writes; indexes outside the register list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recovery_ok <= sfsm_pkg::RECOVERY_OK_RST;
            r_timeout     <= sfsm_pkg::TIMEOUT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == sfsm_pkg::CFG_RECOVERY_OK) begin
                r_recovery_ok <= i_cfg_data[15:0];
            end
            if (i_cfg_index == sfsm_pkg::CFG_TIMEOUT) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    // Faults are counted in every state but fail-silent
    assign cnt_ctrl.count_en   = process && (r_in.func == sfsm_pkg::FUNC_FAULT)
                                 && (r_state != sfsm_pkg::ST_FAILSILENT);
    assign cnt_ctrl.fault_type = r_in.fault_type;

    sfsm_fault_cnt #(
        .FAULT_TYPES (FAULT_TYPES)
    ) u_fault_cnt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (cnt_ctrl),
        .o_status (cnt_status)
    );

    // Time in degraded, wrap-safe: plain modulo-2^32 difference
    assign elapsed = r_in.tick_value - r_start;
    assign ok_inc  = (r_ok_run != '1) ? (r_ok_run + 16'd1) : r_ok_run;

    always_comb begin
        n_state  = r_state;
        n_ok_run = r_ok_run;
        n_start  = r_start;
        n_flag   = r_flag;
        pulse    = 1'b0;
        if (process) begin
            unique case (r_in.func)
                sfsm_pkg::FUNC_FAULT: begin
                    // A fault clears the ok run and escalates one step; degraded goes safe only at the fault limit
                    if (r_state != sfsm_pkg::ST_FAILSILENT) begin
                        n_ok_run = '0;
                        unique case (r_state)
                            sfsm_pkg::ST_NORMAL: begin
                                n_state = sfsm_pkg::ST_DEGRADED;
                                n_start = r_in.tick_value;
                            end
                            sfsm_pkg::ST_DEGRADED: begin
                                if (cnt_status.total_next >= sfsm_pkg::FAULT_LIMIT) begin
                                    n_state = sfsm_pkg::ST_SAFE;
                                    pulse   = 1'b1;
                                end
                            end
                            sfsm_pkg::ST_SAFE: begin
                                n_state = sfsm_pkg::ST_FAILSILENT;
                                pulse   = 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                sfsm_pkg::FUNC_OK: begin
                    // Count consecutive oks only in degraded; enough of them recover
                    if (r_state == sfsm_pkg::ST_DEGRADED) begin
                        if (ok_inc >= r_recovery_ok) begin
                            n_state  = sfsm_pkg::ST_NORMAL;
                            n_ok_run = '0;
                        end else begin
                            n_ok_run = ok_inc;
                        end
                    end
                end
                sfsm_pkg::FUNC_TICK: begin
                    if ((r_state == sfsm_pkg::ST_DEGRADED) && (elapsed >= r_timeout)) begin
                        n_state = sfsm_pkg::ST_SAFE;
                        pulse   = 1'b1;
                    end
                end
                sfsm_pkg::FUNC_TEST: begin
                    // A failed self-test forces safe from anywhere, with no pulse
                    n_flag = r_in.test_pass;
                    if (!r_in.test_pass) begin
                        n_state = sfsm_pkg::ST_SAFE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sfsm_pkg::ST_NORMAL;
            r_ok_run <= '0;
            r_start  <= '0;
            r_flag   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ok_run <= n_ok_run;
            r_start  <= n_start;
            r_flag   <= n_flag;
        end
    end

    // Result register: load on processing, drop once the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out.safety_state      <= sfsm_pkg::state_code(n_state);
            r_out.actuator_allowed  <= (n_state == sfsm_pkg::ST_NORMAL)
                                       || (n_state == sfsm_pkg::ST_DEGRADED);
            r_out.safe_action       <= pulse;
            r_out.total_fault_count <= cnt_status.total_next;
            r_out.type_fault_count  <= (r_in.func == sfsm_pkg::FUNC_FAULT)
                                       ? cnt_status.type_next : 16'd0;
            r_out.self_test_ok      <= n_flag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("supervisor state lost its one-hot form");

    a_failsilent_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && ($past(r_state) == sfsm_pkg::ST_FAILSILENT)
        && (r_state != sfsm_pkg::ST_FAILSILENT) |-> (r_state == sfsm_pkg::ST_SAFE))
        else $error("fail-silent left for a state other than safe");

    a_process_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process |=> r_out_valid)
        else $error("processed event produced no result");

    a_pulse_actuator_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.safe_action |-> !r_out.actuator_allowed)
        else $error("safe action raised while actuators remain allowed");

endmodule
